@@ rtl/cbr_pkg.sv @@
// Shared types, request codes and cycle counts of the branch, call and return unit.
package cbr_pkg;

    // Request codes
    localparam logic [3:0] REQ_JP      = 4'd0;
    localparam logic [3:0] REQ_JP_HL   = 4'd1;
    localparam logic [3:0] REQ_JP_CC   = 4'd2;
    localparam logic [3:0] REQ_JR      = 4'd3;
    localparam logic [3:0] REQ_JR_CC   = 4'd4;
    localparam logic [3:0] REQ_CALL    = 4'd5;
    localparam logic [3:0] REQ_CALL_CC = 4'd6;
    localparam logic [3:0] REQ_RET     = 4'd7;
    localparam logic [3:0] REQ_RET_CC  = 4'd8;
    localparam logic [3:0] REQ_RETI    = 4'd9;
    localparam logic [3:0] REQ_RST     = 4'd10;

    // Cycle counts
    localparam logic [4:0] CYC_4  = 5'd4;
    localparam logic [4:0] CYC_8  = 5'd8;
    localparam logic [4:0] CYC_12 = 5'd12;
    localparam logic [4:0] CYC_16 = 5'd16;
    localparam logic [4:0] CYC_20 = 5'd20;
    localparam logic [4:0] CYC_24 = 5'd24;

    // New PC source
    localparam logic [2:0] PC_KEEP = 3'd0;
    localparam logic [2:0] PC_TGT  = 3'd1;
    localparam logic [2:0] PC_REL  = 3'd2;
    localparam logic [2:0] PC_INC1 = 3'd3;
    localparam logic [2:0] PC_INC2 = 3'd4;

    // New SP source
    localparam logic [1:0] SP_KEEP = 2'd0;
    localparam logic [1:0] SP_DEC2 = 2'd1;
    localparam logic [1:0] SP_INC2 = 2'd2;

    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic [3:0]        req_type;
        logic              flag_value;
        logic              flag_expected;
        logic [15:0]       pc_now;
        logic [15:0]       sp_now;
        logic [15:0]       hl_value;
        logic [15:0]       imm16;
        logic signed [7:0] disp8;
        logic [7:0]        pop_low;
        logic [7:0]        pop_high;
        logic [5:0]        rst_vector;
    } t_cbr_req;

    typedef struct packed {
        logic [15:0] new_pc;
        logic [15:0] new_sp;
        logic        push_valid;
        logic [7:0]  push_high;
        logic [7:0]  push_low;
        logic        set_ime;
        logic        taken;
        logic [4:0]  cycles;
    } t_cbr_rsp;

    typedef struct packed {
        logic [2:0] pc_sel;
        logic [1:0] sp_sel;
        logic       push;
        logic       ret_pc2;
        logic       ime;
        logic       taken;
        logic [4:0] cycles;
    } t_cbr_ctl;

    // Decode stage output
    typedef struct packed {
        t_cbr_ctl    ctl;
        logic [15:0] target;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  disp;
    } t_cbr_dec;

    // Address stage output
    typedef struct packed {
        t_cbr_ctl    ctl;
        logic [15:0] target;
        logic [15:0] pc;
        logic [15:0] pc1;
        logic [15:0] pc2;
        logic [15:0] rel;
        logic [15:0] sp;
        logic [15:0] sp_m2;
        logic [15:0] sp_p2;
    } t_cbr_sum;

endpackage

@@ rtl/cpu_branch_call_return_unit.sv @@
// Top level of the branch, call and return unit: three-stage pipeline with stall flow control.
//
//  channel   direction  handshake            word
//  request   in         i_valid / o_stall    i_word (t_cbr_req)
//  result    out        o_valid / i_stall    o_word (t_cbr_rsp)
//
// A word accepted into the decode register moves through the address register into
// the output register, which raises o_valid; the result is taken at an edge with
// i_stall low, and while o_stall is low one word enters per cycle.
// Stages: decode and condition, address adds (PC+1, PC+2, PC+1+d, SP-2, SP+2),
// result select into the output register.
// Reset (i_rst_n low at a clock edge) empties every stage; the data registers are not reset.
// A stall on the output fills the empty stages behind it first, then holds each
// stage in place; o_stall rises only when all three stages hold a word.
module cpu_branch_call_return_unit import cbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_cbr_req i_word,
    output logic     o_valid,
    input  logic     i_stall,
    output t_cbr_rsp o_word
);

    logic     dec_valid;
    logic     sum_valid;
    logic     out_valid;
    t_cbr_dec dec;
    t_cbr_sum sum;
    logic     adv_out;
    logic     adv_sum;
    logic     adv_dec;

    // A stage advances when it is empty or the stage after it advances.
    assign adv_out = !out_valid || !i_stall;
    assign adv_sum = !sum_valid || adv_out;
    assign adv_dec = !dec_valid || adv_sum;

    // Hold off the sender only when the decode stage cannot take a word.
    assign o_stall = !adv_dec;

    cbr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_dec),
        .i_valid (i_valid),
        .i_req   (i_word),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    cbr_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_sum),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (sum_valid),
        .o_sum   (sum)
    );

    cbr_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_out),
        .i_valid (sum_valid),
        .i_sum   (sum),
        .o_valid (out_valid),
        .o_rsp   (o_word)
    );

    assign o_valid = out_valid;

    // Push bytes read as zero whenever nothing is pushed.
    a_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.push_valid) |-> (o_word.push_high == 8'd0 && o_word.push_low == 8'd0))
        else $error("push bytes nonzero without a push");

    // A not-taken instruction neither pushes nor enables interrupts.
    a_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.taken) |-> (!o_word.push_valid && !o_word.set_ime))
        else $error("side effect on a not-taken instruction");

    // Every push moves SP down by two and carries CYC_16 or CYC_24; only call and rst push.
    a_push_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.push_valid) |-> (o_word.cycles == CYC_16 || o_word.cycles == CYC_24))
        else $error("push with an unexpected cycle count");

    // With the output free, a stall upstream cannot be raised.
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while the output drains");

endmodule

@@ rtl/cbr_decode.sv @@
// Stage one: decode the request, resolve the condition, pick the direct target.
module cbr_decode import cbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_cbr_req i_req,
    output logic     o_valid,
    output t_cbr_dec o_dec
);

    logic     r_valid;
    t_cbr_dec r_dec;
    t_cbr_dec n_dec;
    logic     cond;

    always_comb begin
        cond = (i_req.flag_value == i_req.flag_expected);
        n_dec.pc   = i_req.pc_now;
        n_dec.sp   = i_req.sp_now;
        n_dec.disp = i_req.disp8;
        n_dec.ctl  = '{pc_sel: PC_KEEP, sp_sel: SP_KEEP, push: 1'b0, ret_pc2: 1'b0,
                       ime: 1'b0, taken: 1'b0, cycles: CYC_4};
        n_dec.target = i_req.imm16;
        unique case (i_req.req_type)
            REQ_JP: begin
                n_dec.ctl.pc_sel = PC_TGT;
                n_dec.ctl.taken  = 1'b1;
                n_dec.ctl.cycles = CYC_16;
            end
            REQ_JP_HL: begin
                n_dec.target     = i_req.hl_value;
                n_dec.ctl.pc_sel = PC_TGT;
                n_dec.ctl.taken  = 1'b1;
            end
            REQ_JP_CC: begin
                n_dec.ctl.pc_sel = cond ? PC_TGT : PC_INC2;
                n_dec.ctl.taken  = cond;
                n_dec.ctl.cycles = cond ? CYC_16 : CYC_12;
            end
            REQ_JR: begin
                n_dec.ctl.pc_sel = PC_REL;
                n_dec.ctl.taken  = 1'b1;
                n_dec.ctl.cycles = CYC_12;
            end
            REQ_JR_CC: begin
                n_dec.ctl.pc_sel = cond ? PC_REL : PC_INC1;
                n_dec.ctl.taken  = cond;
                n_dec.ctl.cycles = cond ? CYC_12 : CYC_8;
            end
            REQ_CALL: begin
                n_dec.ctl.pc_sel  = PC_TGT;
                n_dec.ctl.sp_sel  = SP_DEC2;
                n_dec.ctl.push    = 1'b1;
                n_dec.ctl.ret_pc2 = 1'b1;
                n_dec.ctl.taken   = 1'b1;
                n_dec.ctl.cycles  = CYC_24;
            end
            REQ_CALL_CC: begin
                n_dec.ctl.pc_sel  = cond ? PC_TGT : PC_INC2;
                n_dec.ctl.sp_sel  = cond ? SP_DEC2 : SP_KEEP;
                n_dec.ctl.push    = cond;
                n_dec.ctl.ret_pc2 = 1'b1;
                n_dec.ctl.taken   = cond;
                n_dec.ctl.cycles  = cond ? CYC_24 : CYC_12;
            end
            REQ_RET, REQ_RETI: begin
                n_dec.target     = {i_req.pop_high, i_req.pop_low};
                n_dec.ctl.pc_sel = PC_TGT;
                n_dec.ctl.sp_sel = SP_INC2;
                n_dec.ctl.taken  = 1'b1;
                n_dec.ctl.ime    = (i_req.req_type == REQ_RETI);
                n_dec.ctl.cycles = CYC_16;
            end
            REQ_RET_CC: begin
                n_dec.target     = {i_req.pop_high, i_req.pop_low};
                n_dec.ctl.pc_sel = cond ? PC_TGT : PC_KEEP;
                n_dec.ctl.sp_sel = cond ? SP_INC2 : SP_KEEP;
                n_dec.ctl.taken  = cond;
                n_dec.ctl.cycles = cond ? CYC_20 : CYC_8;
            end
            REQ_RST: begin
                n_dec.target     = {10'd0, i_req.rst_vector};
                n_dec.ctl.pc_sel = PC_TGT;
                n_dec.ctl.sp_sel = SP_DEC2;
                n_dec.ctl.push   = 1'b1;
                n_dec.ctl.taken  = 1'b1;
                n_dec.ctl.cycles = CYC_16;
            end
            default: begin
                // unused codes: no-op, defaults above
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

@@ rtl/cbr_addr.sv @@
// Stage two: form every candidate PC and SP with 16-bit wrapping adds.
module cbr_addr import cbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_cbr_dec i_dec,
    output logic     o_valid,
    output t_cbr_sum o_sum
);

    logic     r_valid;
    t_cbr_sum r_sum;
    t_cbr_sum n_sum;

    always_comb begin
        n_sum.ctl    = i_dec.ctl;
        n_sum.target = i_dec.target;
        n_sum.pc     = i_dec.pc;
        n_sum.pc1    = i_dec.pc + 16'd1;
        n_sum.pc2    = i_dec.pc + 16'd2;
        n_sum.rel    = i_dec.pc + 16'd1 + {{8{i_dec.disp[7]}}, i_dec.disp};
        n_sum.sp     = i_dec.sp;
        n_sum.sp_m2  = i_dec.sp - 16'd2;
        n_sum.sp_p2  = i_dec.sp + 16'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

@@ rtl/cbr_select.sv @@
// Stage three: select the results and hold them in the output register.
module cbr_select import cbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_cbr_sum i_sum,
    output logic     o_valid,
    output t_cbr_rsp o_rsp
);

    logic        r_valid;
    t_cbr_rsp    r_rsp;
    t_cbr_rsp    n_rsp;
    logic [15:0] ret_addr;

    always_comb begin
        ret_addr = i_sum.ctl.ret_pc2 ? i_sum.pc2 : i_sum.pc;
        unique case (i_sum.ctl.pc_sel)
            PC_TGT:  n_rsp.new_pc = i_sum.target;
            PC_REL:  n_rsp.new_pc = i_sum.rel;
            PC_INC1: n_rsp.new_pc = i_sum.pc1;
            PC_INC2: n_rsp.new_pc = i_sum.pc2;
            default: n_rsp.new_pc = i_sum.pc;
        endcase
        unique case (i_sum.ctl.sp_sel)
            SP_DEC2: n_rsp.new_sp = i_sum.sp_m2;
            SP_INC2: n_rsp.new_sp = i_sum.sp_p2;
            default: n_rsp.new_sp = i_sum.sp;
        endcase
        n_rsp.push_valid = i_sum.ctl.push;
        // zero the push bytes when nothing is pushed
        n_rsp.push_high  = i_sum.ctl.push ? ret_addr[15:8] : 8'd0;
        n_rsp.push_low   = i_sum.ctl.push ? 8'(ret_addr & BYTE_MASK) : 8'd0;
        n_rsp.set_ime    = i_sum.ctl.ime;
        n_rsp.taken      = i_sum.ctl.taken;
        n_rsp.cycles     = i_sum.ctl.cycles;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
